>>> design/abts_pkg.sv
// abts_pkg: types and constants for the affine b-spline texture sampler
// no dependencies; used by abts_weight and the top level
package abts_pkg;

    localparam int unsigned CfgW   = 32;
    localparam int unsigned WorldW = 24;
    localparam int unsigned TexW   = 16;
    localparam int unsigned AddrW  = 16;
    localparam int unsigned IdxW   = 3;
    localparam int unsigned NumCfg = 6;

    // register indexes
    localparam logic [IdxW-1:0] RegXx = 3'd0;
    localparam logic [IdxW-1:0] RegXy = 3'd1;
    localparam logic [IdxW-1:0] RegXt = 3'd2;
    localparam logic [IdxW-1:0] RegYx = 3'd3;
    localparam logic [IdxW-1:0] RegYy = 3'd4;
    localparam logic [IdxW-1:0] RegYt = 3'd5;

    localparam logic KindLoad   = 1'b0;
    localparam logic KindSample = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_SCALE,
        S_SPLIT,
        S_WGT,
        S_ADDR,
        S_READ,
        S_MAC1,
        S_MAC2,
        S_ROUND,
        S_OUT
    } t_state;

    // request/response between top level and weight unit
    typedef struct packed {
        logic        start;
        logic [15:0] t;
    } t_wreq;

    typedef struct packed {
        logic        done;
        logic [16:0] w0;
        logic [16:0] w1;
        logic [16:0] w2;
        logic [16:0] w3;
    } t_wrsp;

endpackage

>>> design/abts_weight.sv
// abts_weight: cubic b-spline weights for one Q0.16 fraction
// uses abts_pkg; one shared multiplier, reciprocal divide by six
module abts_weight (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  abts_pkg::t_wreq i_req,
    output abts_pkg::t_wrsp o_rsp
);
    import abts_pkg::*;

    // step codes
    localparam logic [3:0] StT2 = 4'd0;
    localparam logic [3:0] StT3 = 4'd1;
    localparam logic [3:0] StS2 = 4'd2;
    localparam logic [3:0] StS3 = 4'd3;
    localparam logic [3:0] StD0 = 4'd4;
    localparam logic [3:0] StD2 = 4'd5;
    localparam logic [3:0] StD3 = 4'd6;
    localparam logic [3:0] StEnd = 4'd7;
    localparam logic [3:0] StDone = 4'd8;

    // ceil(2^22 / 6): exact floor division by six for numerators below 2^21
    localparam logic [19:0] RecipSix = 20'd699051;

    logic        r_busy;
    logic [3:0]  r_step;
    logic [16:0] r_t, r_s;
    logic [33:0] r_t2, r_s2;
    logic [50:0] r_t3, r_s3;
    logic [16:0] r_w0, r_w2, r_w3;
    logic        r_done;
    // divider
    logic [19:0] r_y;
    logic [16:0] r_quo;
    logic        r_dact;

    logic [33:0] mul_a;
    logic [16:0] mul_b;
    logic [50:0] mul_p;
    logic [51:0] n2, dnum;
    logic [39:0] recip_p;
    logic [17:0] sum3;

    // shared multiplier operands
    always_comb begin
        mul_a = r_t2;
        mul_b = r_t;
        case (r_step)
            StT2:    begin mul_a = {17'd0, r_t}; mul_b = r_t; end
            StT3:    begin mul_a = r_t2;         mul_b = r_t; end
            StS2:    begin mul_a = {17'd0, r_s}; mul_b = r_s; end
            StS3:    begin mul_a = r_s2;         mul_b = r_s; end
            default: begin mul_a = r_t2;         mul_b = r_t; end
        endcase
    end
    assign mul_p = 51'(mul_a * mul_b);

    // middle numerator 2^48 + 3t*2^32 + 3t^2*2^16 - 3t^3
    assign n2 = (52'd1 << 48) + 52'(3 * ({35'd0, r_t} << 32))
              + 52'(3 * ({18'd0, r_t2} << 16)) - 52'(3 * {1'b0, r_t3});

    always_comb begin
        case (r_step)
            StD0:    dnum = {1'b0, r_s3} + (52'd3 << 32);
            StD2:    dnum = n2 + (52'd3 << 32);
            default: dnum = {1'b0, r_t3} + (52'd3 << 32);
        endcase
    end

    // divide by 6<<32: drop the low 32 bits, then multiply by the reciprocal of six
    assign recip_p = 40'(r_y) * 40'(RecipSix);
    assign sum3    = 18'(r_w0) + 18'(r_w2) + 18'(r_w3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_dact <= 1'b0;
            r_step <= StT2;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= StT2;
                r_t    <= {1'b0, i_req.t};
                r_s    <= 17'h10000 - {1'b0, i_req.t};
                r_dact <= 1'b0;
            end else if (r_busy) begin
                if (r_dact) begin
                    // quotient of the scaled numerator
                    r_quo  <= 17'(recip_p >> 22);
                    r_dact <= 1'b0;
                    r_step <= r_step + 4'd1;
                end else begin
                    unique case (r_step)
                        StT2: begin r_t2 <= 34'(mul_p); r_step <= StT3; end
                        StT3: begin r_t3 <= mul_p; r_step <= StS2; end
                        StS2: begin r_s2 <= 34'(mul_p); r_step <= StS3; end
                        StS3: begin r_s3 <= mul_p; r_step <= StD0; end
                        StD0, StD2, StD3: begin
                            // capture the previous quotient, then start the next divide
                            if (r_step == StD2) r_w0 <= r_quo;
                            if (r_step == StD3) r_w2 <= r_quo;
                            r_y    <= dnum[51:32];
                            r_dact <= 1'b1;
                        end
                        StEnd: begin
                            r_w3   <= r_quo;
                            r_step <= StDone;
                        end
                        default: begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // tap 1 weight takes the remainder of one
    assign o_rsp.done = r_done;
    assign o_rsp.w0 = r_w0;
    assign o_rsp.w2 = r_w2;
    assign o_rsp.w3 = r_w3;
    assign o_rsp.w1 = (sum3 > 18'h10000) ? 17'd0 : 17'(18'h10000 - sum3);

endmodule

>>> design/affine_bspline_texture_sampler_core.sv
// affine_bspline_texture_sampler_core: texture store, affine map and 4x4 b-spline sampling
// uses abts_pkg and abts_weight
//
// channel | dir | signals                    | content
// s_axis  | in  | s_axis_tvalid/tready/tdata | kind in tuser, texel and world fields in tdata
// m_axis  | out | m_axis_tvalid/tready/tdata | sample_value
// cfg     | in  | i_cfg_valid/ready/idx/data | matrix registers
//
// a load is written to the store when it is accepted; a sample runs the affine map and support
// test, then the two weight sets, then the sixteen taps (address, read and two passes through the
// one shared multiplier each); a point outside support goes from the support test straight to
// the output with a zero result.
// reset clears the sequencer and restores the identity matrix; the store is not cleared.
// a finished sample waits in the output register; input is refused until it is taken.
module affine_bspline_texture_sampler_core #(
    parameter int unsigned TEXTURE_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] texel_index, [31:16] texel_value, [55:32] world_x, [79:56] world_y
    input  logic [79:0] s_axis_tdata,
    // [0] kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] sample_value
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [abts_pkg::IdxW-1:0] i_cfg_idx,
    input  logic [abts_pkg::CfgW-1:0] i_cfg_data
);
    import abts_pkg::*;

    localparam int unsigned TsW = $clog2(TEXTURE_SIZE);
    localparam logic signed [47:0] Lim = 48'sd1 <<< 45;

    // config registers
    logic signed [31:0] r_m [NumCfg];
    // texture store
    logic [TexW-1:0] r_store [1 << AddrW];
    logic [TexW-1:0] r_rd;

    t_state r_state, n_state;
    logic signed [23:0] r_wx, r_wy;
    logic [2:0]  r_mcnt;
    logic signed [57:0] r_ox, r_oy;
    logic [1:0]  r_ax;       // 0 x, 1 y
    logic        r_in;
    logic signed [57:0] r_ux, r_uy;
    logic signed [13:0] r_fx, r_fy;
    logic [15:0] r_tx, r_ty;
    logic [16:0] r_wxs [4];
    logic [16:0] r_wys [4];
    logic [3:0]  r_tap;
    logic [AddrW-1:0] r_addr;
    logic [33:0] r_prod;
    logic [50:0] r_acc;
    logic [15:0] r_res;
    logic        r_ovalid;
    logic        r_wstart;

    t_wreq wreq;
    t_wrsp wrsp;

    abts_weight u_weight (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(wreq), .o_rsp(wrsp)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_res;

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // shared multiplier: 32x24 for the matrix, 17x17 and 34x16 for the taps
    logic signed [34:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [59:0] mul_p;
    logic [2:0] mi;
    always_comb begin
        mi = r_mcnt;
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL: begin
                mul_a = 35'(r_m[mi]);
                case (r_mcnt)
                    3'd0, 3'd3: mul_b = 25'(r_wx);
                    3'd1, 3'd4: mul_b = 25'(r_wy);
                    default:    mul_b = 25'sd1 <<< 20;
                endcase
            end
            S_MAC1: begin
                mul_a = 35'({1'b0, r_wxs[r_tap[1:0]]});
                mul_b = 25'({1'b0, r_wys[r_tap[3:2]]});
            end
            S_MAC2: begin
                mul_a = 35'({1'b0, r_prod});
                mul_b = 25'({1'b0, r_rd});
            end
            default: ;
        endcase
        mul_p = 60'(mul_a * mul_b);
    end

    // tap address from clamped indices
    logic signed [14:0] gxs, gys;
    logic [TsW-1:0] gx, gy;
    always_comb begin
        gxs = 15'(r_fx) - 15'sd1 + 15'($signed({1'b0, r_tap[1:0]}));
        gys = 15'(r_fy) - 15'sd1 + 15'($signed({1'b0, r_tap[3:2]}));
        gx = (gxs < 0) ? '0 : (gxs > 15'(TEXTURE_SIZE - 1)) ? TsW'(TEXTURE_SIZE - 1)
           : TsW'(gxs);
        gy = (gys < 0) ? '0 : (gys > 15'(TEXTURE_SIZE - 1)) ? TsW'(TEXTURE_SIZE - 1)
           : TsW'(gys);
    end

    // support test and scaling on the current axis
    logic signed [57:0] a_cur, u_cur;
    logic signed [67:0] u_mul;
    logic signed [57:0] split_v;
    assign a_cur = (r_ax == 2'd0) ? r_ox + (58'sd1 <<< 43) : r_oy + (58'sd1 <<< 43);
    assign u_mul = 68'(a_cur) * 68'(TEXTURE_SIZE - 1);
    assign u_cur = 58'(u_mul);
    assign split_v = ((r_ax == 2'd0) ? r_ux : r_uy) + (58'sd2 <<< 44);

    // round and saturate
    logic [18:0] rnd;
    assign rnd = 19'((r_acc + (51'd1 << 31)) >> 32);

    // matrix registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m[RegXx] <= 32'sd16777216; r_m[RegXy] <= '0; r_m[RegXt] <= '0;
            r_m[RegYx] <= '0; r_m[RegYy] <= 32'sd16777216; r_m[RegYt] <= '0;
        end else if (i_cfg_valid && i_cfg_idx < IdxW'(NumCfg)) begin
            r_m[i_cfg_idx] <= i_cfg_data;
        end
    end

    // store port: load writes, tap reads
    always_ff @(posedge i_clk) begin
        if (in_acc && s_axis_tuser == KindLoad)
            r_store[s_axis_tdata[15:0]] <= s_axis_tdata[31:16];
        r_rd <= r_store[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc && s_axis_tuser == KindSample) n_state = S_MUL;
            S_MUL:   if (r_mcnt == 3'd5) n_state = S_CHECK;
            S_CHECK: n_state = (r_ax == 2'd1) ? S_SCALE : S_CHECK;
            S_SCALE: n_state = r_in ? S_SPLIT : S_OUT;
            S_SPLIT: n_state = (r_ax == 2'd1) ? S_WGT : S_SPLIT;
            S_WGT:   if (wrsp.done && r_ax == 2'd1) n_state = S_ADDR;
            S_ADDR:  n_state = S_READ;
            S_READ:  n_state = S_MAC1;
            S_MAC1:  n_state = S_MAC2;
            S_MAC2:  n_state = (r_tap == 4'd15) ? S_ROUND : S_ADDR;
            S_ROUND: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign wreq.start = r_wstart;
    assign wreq.t = (r_ax == 2'd0) ? r_tx : r_ty;

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_wstart <= 1'b0;
        end else begin
            r_wstart <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_wx <= $signed(s_axis_tdata[55:32]);
                    r_wy <= $signed(s_axis_tdata[79:56]);
                    r_mcnt <= 3'd0;
                    r_ox <= '0;
                    r_oy <= '0;
                    r_ax <= 2'd0;
                    r_in <= 1'b1;
                end
                S_MUL: begin
                    if (r_mcnt < 3'd3) r_ox <= r_ox + 58'(mul_p);
                    else r_oy <= r_oy + 58'(mul_p);
                    r_mcnt <= r_mcnt + 3'd1;
                end
                S_CHECK: begin
                    if (a_cur < 58'(-Lim) || a_cur > 58'(Lim) ||
                        u_cur < -(58'sd1 <<< 44) ||
                        u_cur > ($signed(58'(TEXTURE_SIZE)) <<< 44)) r_in <= 1'b0;
                    if (r_ax == 2'd0) r_ux <= u_cur; else r_uy <= u_cur;
                    r_ax <= (r_ax == 2'd0) ? 2'd1 : 2'd0;
                end
                S_SCALE: begin
                    r_ax <= 2'd0;
                    if (!r_in) begin
                        r_res <= '0;
                        r_ovalid <= 1'b1;
                    end
                end
                S_SPLIT: begin
                    if (r_ax == 2'd0) begin
                        r_fx <= 14'(split_v >>> 44) - 14'sd2;
                        r_tx <= split_v[43:28];
                        r_ax <= 2'd1;
                    end else begin
                        r_fy <= 14'(split_v >>> 44) - 14'sd2;
                        r_ty <= split_v[43:28];
                        r_ax <= 2'd0;
                        r_wstart <= 1'b1;
                    end
                end
                S_WGT: begin
                    if (wrsp.done) begin
                        if (r_ax == 2'd0) begin
                            r_wxs[0] <= wrsp.w0; r_wxs[1] <= wrsp.w1;
                            r_wxs[2] <= wrsp.w2; r_wxs[3] <= wrsp.w3;
                            r_ax <= 2'd1;
                            r_wstart <= 1'b1;
                        end else begin
                            r_wys[0] <= wrsp.w0; r_wys[1] <= wrsp.w1;
                            r_wys[2] <= wrsp.w2; r_wys[3] <= wrsp.w3;
                        end
                    end
                    r_tap <= 4'd0;
                    r_acc <= '0;
                end
                S_ADDR: r_addr <= AddrW'(32'(gx) + 32'(TEXTURE_SIZE) * 32'(gy));
                S_READ: ;
                S_MAC1: r_prod <= 34'(mul_p);
                S_MAC2: begin
                    r_acc <= r_acc + 51'(mul_p);
                    r_tap <= r_tap + 4'd1;
                end
                S_ROUND: r_res <= (rnd > 19'd32768) ? 16'd32768 : 16'(rnd);
                S_OUT: if (r_in) r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule
